FILE: rtl/core/sha_pkg.sv
// ----------------------------------------------------------------------------
// sha_pkg
// shared types, constants and round functions for the byte-stream hasher
// ----------------------------------------------------------------------------
package sha_pkg;

    localparam int unsigned CNT_W       = 61;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned OUT_DEPTH   = 8;

    typedef logic [31:0] word_t;

    // byte handed from front to back: message, pad or length byte
    typedef struct packed {
        logic [7:0] data;
        logic       last;   // final byte of the padded stream
    } pbyte_t;

    typedef struct packed {
        word_t      word;
        logic [2:0] index;
        logic       last;
    } dword_t;

    localparam word_t INIT_VEC [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam word_t ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    localparam logic [7:0] PAD_BYTE  = 8'h80;
    localparam logic [5:0] LEN_START = 6'd56;

    function automatic word_t ror(input word_t x, input int unsigned n);
        ror = (x >> n) | (x << (32 - n));
    endfunction

    function automatic word_t sig0(input word_t x);
        sig0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t sig1(input word_t x);
        sig1 = ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
    endfunction

    function automatic word_t bsig0(input word_t x);
        bsig0 = ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
    endfunction

    function automatic word_t bsig1(input word_t x);
        bsig1 = ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
    endfunction

endpackage

FILE: rtl/core/sha_front.sv
// ----------------------------------------------------------------------------
// sha_front
// takes message bytes, counts them and generates padding and length bytes
// ----------------------------------------------------------------------------
module sha_front
    import sha_pkg::*;
#(
    parameter int unsigned CntW = CNT_W
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] data_byte,
    input  logic       final_byte,
    output logic       q_valid,
    output pbyte_t     q_data,
    input  logic       q_ready
);

    typedef enum logic [2:0] {
        ST_MSG = 3'b001,
        ST_PAD = 3'b010,
        ST_LEN = 3'b100
    } fstate_t;

    fstate_t         state_reg, state_next;
    logic [CntW-1:0] count_reg, count_next;
    logic [5:0]      pos_reg, pos_next;
    logic [2:0]      len_reg, len_next;
    logic [63:0]     bits;
    logic            take;

    assign bits = 64'({count_reg, 3'b000});
    assign full = (state_reg != ST_MSG) || !q_ready;
    assign take = push && !full;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        pos_next   = pos_reg;
        len_next   = len_reg;
        q_valid    = 1'b0;
        q_data     = '0;
        case (state_reg)
            ST_MSG:
            begin
                q_valid = push;
                q_data  = '{data: data_byte, last: 1'b0};
                if (take)
                begin
                    count_next = count_reg + 1'b1;
                    pos_next   = pos_reg + 1'b1;
                    if (final_byte)
                        state_next = ST_PAD;
                end
            end
            ST_PAD:
            begin
                // marker byte first, zeros until offset 56
                q_valid = 1'b1;
                q_data  = '{data: (len_reg == 3'd0) ? PAD_BYTE : 8'h00, last: 1'b0};
                if (q_ready)
                begin
                    len_next = 3'd1;
                    pos_next = pos_reg + 1'b1;
                    if (pos_reg + 1'b1 == LEN_START)
                    begin
                        state_next = ST_LEN;
                        len_next   = 3'd0;
                    end
                end
            end
            ST_LEN:
            begin
                q_valid = 1'b1;
                q_data  = '{data: bits[8*(7-len_reg) +: 8], last: (len_reg == 3'd7)};
                if (q_ready)
                begin
                    len_next = len_reg + 1'b1;
                    if (len_reg == 3'd7)
                    begin
                        state_next = ST_MSG;
                        count_next = '0;
                        pos_next   = '0;
                    end
                end
            end
            default:
            begin
                state_next = ST_MSG;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_MSG;
            count_reg <= '0;
            pos_reg   <= '0;
            len_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pos_reg   <= pos_next;
            len_reg   <= len_next;
        end
    end

endmodule

FILE: rtl/core/sha_queue.sv
// ----------------------------------------------------------------------------
// sha_queue
// short byte queue between the front and the compression engine
// ----------------------------------------------------------------------------
module sha_queue
    import sha_pkg::*;
#(
    parameter int unsigned Depth = QUEUE_DEPTH
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    input  pbyte_t in_data,
    output logic   out_valid,
    input  logic   out_ready,
    output pbyte_t out_data
);

    localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

    pbyte_t        mem_reg [Depth];
    logic [AW-1:0] wr_reg, rd_reg;
    logic [AW:0]   cnt_reg;
    logic          wr_en, rd_en;

    assign in_ready  = (cnt_reg != Depth[AW:0]);
    assign out_valid = (cnt_reg != '0);
    assign out_data  = mem_reg[rd_reg];
    assign wr_en     = in_valid && in_ready;
    assign rd_en     = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_reg] <= in_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en)
                wr_reg <= (wr_reg == AW'(Depth - 1)) ? '0 : wr_reg + 1'b1;
            if (rd_en)
                rd_reg <= (rd_reg == AW'(Depth - 1)) ? '0 : rd_reg + 1'b1;
            cnt_reg <= cnt_reg + {{AW{1'b0}}, wr_en} - {{AW{1'b0}}, rd_en};
        end
    end

endmodule

FILE: rtl/core/sha_back.sv
// ----------------------------------------------------------------------------
// sha_back
// gathers 64-byte blocks, runs one round per cycle and queues the digest
// ----------------------------------------------------------------------------
module sha_back
    import sha_pkg::*;
#(
    parameter int unsigned OutDepth = OUT_DEPTH
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    input  pbyte_t in_data,
    output logic   empty,
    input  logic   pop,
    output dword_t out_data
);

    typedef enum logic [3:0] {
        ST_FILL = 4'b0001,
        ST_RUN  = 4'b0010,
        ST_ADD  = 4'b0100,
        ST_EMIT = 4'b1000
    } bstate_t;

    localparam int unsigned OAW = $clog2(OutDepth);

    bstate_t      state_reg;
    logic [5:0]   pos_reg;
    logic [5:0]   rnd_reg;
    logic         fin_reg;
    logic [2:0]   emit_reg;
    word_t        w_reg   [16];
    word_t        v_reg   [8];
    word_t        h_reg   [8];
    dword_t       oq_reg  [OutDepth];
    logic [OAW-1:0] owr_reg, ord_reg;
    logic [OAW:0]   ocnt_reg;
    logic         take, owr_en, ord_en;
    word_t        wr_word, t1, t2, w_new;
    word_t        a, e;

    assign take     = in_valid && in_ready;
    // a new block is not begun while digest words still fill the output queue
    assign in_ready = (state_reg == ST_FILL) && (ocnt_reg == '0);
    assign empty    = (ocnt_reg == '0);
    assign out_data = oq_reg[ord_reg];
    assign ord_en   = pop && !empty;
    assign owr_en   = (state_reg == ST_EMIT);

    assign a       = v_reg[0];
    assign e       = v_reg[4];
    assign wr_word = w_reg[0];
    assign t1 = v_reg[7] + bsig1(e) + ((e & v_reg[5]) ^ (~e & v_reg[6]))
              + ROUND_K[rnd_reg] + wr_word;
    assign t2 = bsig0(a) + ((a & v_reg[1]) ^ (a & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    assign w_new = w_reg[0] + sig0(w_reg[1]) + w_reg[9] + sig1(w_reg[14]);

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            // bytes shift into the schedule window, big-endian
            w_reg[pos_reg[5:2]] <= {w_reg[pos_reg[5:2]][23:0], in_data.data};
        end
        else if (state_reg == ST_RUN)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i+1];
            w_reg[15] <= w_new;
        end
        if (owr_en)
            oq_reg[owr_reg] <= '{word: h_reg[emit_reg], index: emit_reg,
                                 last: (emit_reg == 3'd7)};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_FILL;
            pos_reg   <= '0;
            rnd_reg   <= '0;
            fin_reg   <= 1'b0;
            emit_reg  <= '0;
            owr_reg   <= '0;
            ord_reg   <= '0;
            ocnt_reg  <= '0;
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= INIT_VEC[i];
                v_reg[i] <= INIT_VEC[i];
            end
        end
        else
        begin
            if (ord_en)
                ord_reg <= (ord_reg == OAW'(OutDepth - 1)) ? '0 : ord_reg + 1'b1;
            if (owr_en)
                owr_reg <= (owr_reg == OAW'(OutDepth - 1)) ? '0 : owr_reg + 1'b1;
            ocnt_reg <= ocnt_reg + {{OAW{1'b0}}, owr_en} - {{OAW{1'b0}}, ord_en};
            case (state_reg)
                ST_FILL:
                begin
                    if (take)
                    begin
                        pos_reg <= pos_reg + 1'b1;
                        if (pos_reg == 6'd63)
                        begin
                            fin_reg   <= in_data.last;
                            rnd_reg   <= '0;
                            state_reg <= ST_RUN;
                            for (int i = 0; i < 8; i++)
                                v_reg[i] <= h_reg[i];
                        end
                    end
                end
                ST_RUN:
                begin
                    v_reg[7] <= v_reg[6];
                    v_reg[6] <= v_reg[5];
                    v_reg[5] <= v_reg[4];
                    v_reg[4] <= v_reg[3] + t1;
                    v_reg[3] <= v_reg[2];
                    v_reg[2] <= v_reg[1];
                    v_reg[1] <= v_reg[0];
                    v_reg[0] <= t1 + t2;
                    rnd_reg  <= rnd_reg + 1'b1;
                    if (rnd_reg == 6'd63)
                        state_reg <= ST_ADD;
                end
                ST_ADD:
                begin
                    for (int i = 0; i < 8; i++)
                        h_reg[i] <= h_reg[i] + v_reg[i];
                    emit_reg  <= '0;
                    state_reg <= fin_reg ? ST_EMIT : ST_FILL;
                end
                ST_EMIT:
                begin
                    emit_reg <= emit_reg + 1'b1;
                    if (emit_reg == 3'd7)
                    begin
                        state_reg <= ST_FILL;
                        for (int i = 0; i < 8; i++)
                            h_reg[i] <= INIT_VEC[i];
                    end
                end
                default:
                begin
                    state_reg <= ST_FILL;
                end
            endcase
        end
    end

    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> !take)
        else $error("byte taken during compression");
    a_oq_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ocnt_reg <= OutDepth[OAW:0])
        else $error("digest queue overflow");
    a_emit_after_add: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == ST_EMIT) |-> $past(state_reg == ST_ADD) && $past(fin_reg))
        else $error("digest emitted without final block");
    a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN && rnd_reg == 6'd63) |=> (state_reg == ST_ADD))
        else $error("round count slip");

endmodule

FILE: rtl/core/sha256_byte_stream_hasher.sv
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher
// byte-wide sha-256 hasher emitting eight digest words per message
// ----------------------------------------------------------------------------
//  channel   handshake        payload
//  input     push / full      data_byte, final_byte
//  result    empty / pop      digest_word, word_index, last_word
//
//  bytes are taken while full is low; a four-byte queue sits between front and back
//  every 64th byte starts 64 rounds (one per cycle) plus a chain
//  update; full goes high once the byte queue has filled behind it
//  after the final byte the front issues 9 to 72 pad and length bytes, full high
//  the digest is written into an eight-word result queue one word at a time, and
//  no new block is taken until all eight words have been popped
//  reset (rst_n low, asynchronous) loads the initial vector, no clearing pass
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher
    import sha_pkg::*;
#(
    parameter int unsigned QueueDepth = QUEUE_DEPTH,
    parameter int unsigned OutDepth   = OUT_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    input  logic        final_byte,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);

    pbyte_t f_data, b_data;
    logic   f_valid, f_ready, b_valid, b_ready;
    dword_t o_data;

    sha_front #(.CntW(CNT_W)) u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .data_byte(data_byte), .final_byte(final_byte),
        .q_valid(f_valid), .q_data(f_data), .q_ready(f_ready));

    sha_queue #(.Depth(QueueDepth)) u_queue (
        .clk(clk), .rst_n(rst_n), .in_valid(f_valid), .in_ready(f_ready),
        .in_data(f_data), .out_valid(b_valid), .out_ready(b_ready),
        .out_data(b_data));

    sha_back #(.OutDepth(OutDepth)) u_back (
        .clk(clk), .rst_n(rst_n), .in_valid(b_valid), .in_ready(b_ready),
        .in_data(b_data), .empty(empty), .pop(pop), .out_data(o_data));

    assign digest_word = o_data.word;
    assign word_index  = o_data.index;
    assign last_word   = o_data.last;

endmodule
